@@ hdl/rvo_pkg.sv @@
`default_nettype none
package rvo_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int FRAME_WIDTH_RST = 1920;
    localparam int FRAME_HEIGHT_RST = 1080;
    localparam int HELD_RST        = 255;

    localparam int OPACITY_W  = 8;
    localparam int SCALE_W    = 10;
    localparam int SCALE      = 1000;
    localparam int OPACITY_MAX = 240;
    localparam int SAT_MUL    = OPACITY_MAX + 1;
    localparam int DIV_STEPS  = OPACITY_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQX,
        OP_SQY,
        OP_SUM,
        OP_ROOT,
        OP_SCALE,
        OP_DIV,
        OP_SAT,
        OP_HOLD,
        OP_DONE
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_IN,
        C_NO_RECOMP,
        C_CNT_NZ,
        C_NUM_GE,
        C_OUT_BUSY
    } t_cond;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_WAIT  = 4'd0;
    localparam t_step ST_SQX   = 4'd1;
    localparam t_step ST_SQY   = 4'd2;
    localparam t_step ST_SUM   = 4'd3;
    localparam t_step ST_ROOT  = 4'd4;
    localparam t_step ST_SCALE = 4'd5;
    localparam t_step ST_CHK   = 4'd6;
    localparam t_step ST_DIV   = 4'd7;
    localparam t_step ST_DONE  = 4'd8;
    localparam t_step ST_HOLD  = 4'd9;
    localparam t_step ST_SAT   = 4'd10;

    // stay: while cond is true, remain on this step with the op suppressed;
    // otherwise go to target. Without stay: cond true jumps, else falls through.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  stay;
        t_step target;
    } t_cw;

    typedef struct packed {
        t_op  op;
        logic en;
    } t_ctl;

    typedef struct packed {
        logic recomp;
        logic cnt_nz;
        logic num_ge;
    } t_dp_stat;

    typedef struct packed {
        logic     in_acc;
        logic     out_busy;
        t_dp_stat dp;
    } t_stat;

    function automatic t_cw ucode(input t_step addr);
        t_cw cw;
        cw = '{op: OP_NOP, cond: C_ALWAYS, stay: 1'b0, target: ST_WAIT};
        unique case (addr)
            ST_WAIT:  cw = '{op: OP_LOAD,  cond: C_NO_IN,     stay: 1'b1, target: ST_SQX};
            ST_SQX:   cw = '{op: OP_SQX,   cond: C_NO_RECOMP, stay: 1'b0, target: ST_HOLD};
            ST_SQY:   cw = '{op: OP_SQY,   cond: C_NEXT,      stay: 1'b0, target: ST_WAIT};
            ST_SUM:   cw = '{op: OP_SUM,   cond: C_NEXT,      stay: 1'b0, target: ST_WAIT};
            ST_ROOT:  cw = '{op: OP_ROOT,  cond: C_CNT_NZ,    stay: 1'b0, target: ST_ROOT};
            ST_SCALE: cw = '{op: OP_SCALE, cond: C_NEXT,      stay: 1'b0, target: ST_WAIT};
            ST_CHK:   cw = '{op: OP_NOP,   cond: C_NUM_GE,    stay: 1'b0, target: ST_SAT};
            ST_DIV:   cw = '{op: OP_DIV,   cond: C_CNT_NZ,    stay: 1'b0, target: ST_DIV};
            ST_DONE:  cw = '{op: OP_DONE,  cond: C_OUT_BUSY,  stay: 1'b1, target: ST_WAIT};
            ST_HOLD:  cw = '{op: OP_HOLD,  cond: C_ALWAYS,    stay: 1'b0, target: ST_DONE};
            ST_SAT:   cw = '{op: OP_SAT,   cond: C_ALWAYS,    stay: 1'b0, target: ST_DONE};
            default:  cw = '{op: OP_NOP,   cond: C_ALWAYS,    stay: 1'b0, target: ST_WAIT};
        endcase
        return cw;
    endfunction

endpackage
`default_nettype wire

@@ hdl/rvo_seq.sv @@
`default_nettype none
module rvo_seq (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  rvo_pkg::t_stat i_stat,
    output rvo_pkg::t_ctl  o_ctl,
    output logic           o_in_stall
);
    import rvo_pkg::*;

    t_step r_step;
    t_step n_step;
    t_cw   cw;
    logic  cond_true;

    assign cw         = ucode(r_step);
    assign o_in_stall = cw.op != OP_LOAD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        unique case (cw.cond)
            C_NEXT:      cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_IN:     cond_true = !i_stat.in_acc;
            C_NO_RECOMP: cond_true = !i_stat.dp.recomp;
            C_CNT_NZ:    cond_true = i_stat.dp.cnt_nz;
            C_NUM_GE:    cond_true = i_stat.dp.num_ge;
            C_OUT_BUSY:  cond_true = i_stat.out_busy;
            default:     cond_true = 1'b1;
        endcase
        o_ctl.op = cw.op;
        o_ctl.en = !(cw.stay && cond_true);
        priority if (cw.stay && cond_true) begin
            n_step = r_step;
        end else if (cw.stay || cond_true) begin
            n_step = cw.target;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

endmodule
`default_nettype wire

@@ hdl/rvo_dp.sv @@
`default_nettype none
module rvo_dp #(
    parameter int COORD_BITS = rvo_pkg::COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  rvo_pkg::t_ctl                i_ctl,
    input  wire [COORD_BITS-1:0]         i_frame_width,
    input  wire [COORD_BITS-1:0]         i_frame_height,
    input  wire [COORD_BITS-1:0]         i_pixel_x,
    input  wire [COORD_BITS-1:0]         i_pixel_y,
    output rvo_pkg::t_dp_stat            o_stat,
    output logic [rvo_pkg::OPACITY_W-1:0] o_quo
);
    import rvo_pkg::*;

    localparam int C       = COORD_BITS;
    localparam int PROD_W  = 2 * C;
    localparam int V_W     = 2 * C + 1;
    localparam int NUM_W   = C + 1 + SCALE_W;
    localparam int LIM_W   = C + OPACITY_W;
    localparam int CNT_MAX = (C > DIV_STEPS - 1) ? C : DIV_STEPS - 1;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    localparam logic [SCALE_W-1:0]   SCALE_K = SCALE_W'(SCALE);
    localparam logic [OPACITY_W-1:0] SAT_K   = OPACITY_W'(SAT_MUL);
    localparam logic [OPACITY_W-1:0] OP_MAX  = OPACITY_W'(OPACITY_MAX);

    logic [C-1:0]         r_dx, r_dy;
    logic                 r_recomp;
    logic [PROD_W-1:0]    r_prod;
    logic [V_W-1:0]       r_v, r_root, r_bit;
    logic [NUM_W-1:0]     r_num;
    logic [LIM_W-1:0]     r_lim;
    logic [CNT_W-1:0]     r_cnt;
    logic [OPACITY_W-1:0] r_quo, r_held;

    logic [C-1:0]     half_w, half_h, dx_next, dy_next;
    logic [V_W:0]     root_trial;
    logic             root_ge;
    logic [NUM_W-1:0] num_scaled, div_sh, lim_ext;
    logic [LIM_W-1:0] lim_next;
    logic             div_ge;

    always_comb begin
        half_w     = i_frame_width >> 1;
        half_h     = i_frame_height >> 1;
        dx_next    = (i_pixel_x >= half_w) ? i_pixel_x - half_w : half_w - i_pixel_x;
        dy_next    = (i_pixel_y >= half_h) ? i_pixel_y - half_h : half_h - i_pixel_y;
        root_trial = {1'b0, r_root} + {1'b0, r_bit};
        root_ge    = {1'b0, r_v} >= root_trial;
        num_scaled = NUM_W'(r_root[C:0]) * NUM_W'(SCALE_K);
        lim_next   = LIM_W'(i_frame_width) * LIM_W'(SAT_K);
        lim_ext    = {{(NUM_W - LIM_W){1'b0}}, r_lim};
        div_sh     = {{(NUM_W - C){1'b0}}, i_frame_width} << r_cnt;
        div_ge     = r_num >= div_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= OPACITY_W'(HELD_RST);
        end else if (i_ctl.en && i_ctl.op == OP_DONE) begin
            r_held <= r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            unique case (i_ctl.op)
                OP_LOAD: begin
                    r_dx     <= dx_next;
                    r_dy     <= dy_next;
                    r_recomp <= (i_pixel_x[1:0] == 2'b00) || (i_pixel_y[1:0] == 2'b00);
                end
                OP_SQX: r_prod <= PROD_W'(r_dx) * PROD_W'(r_dx);
                OP_SQY: begin
                    r_v    <= {1'b0, r_prod};
                    r_prod <= PROD_W'(r_dy) * PROD_W'(r_dy);
                end
                OP_SUM: begin
                    r_v    <= r_v + {1'b0, r_prod};
                    r_root <= '0;
                    r_bit  <= {1'b1, {PROD_W{1'b0}}};
                    r_cnt  <= CNT_W'(C);
                end
                OP_ROOT: begin
                    if (root_ge) begin
                        r_v    <= r_v - root_trial[V_W-1:0];
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                OP_SCALE: begin
                    r_num <= num_scaled;
                    r_lim <= lim_next;
                    r_cnt <= CNT_W'(DIV_STEPS - 1);
                    r_quo <= '0;
                end
                OP_DIV: begin
                    if (div_ge) begin
                        r_num <= r_num - div_sh;
                    end
                    r_quo <= {r_quo[OPACITY_W-2:0], div_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                OP_SAT:  r_quo <= OP_MAX;
                OP_HOLD: r_quo <= (r_held > OP_MAX) ? OP_MAX : r_held;
                default: ;
            endcase
        end
    end

    assign o_stat.recomp = r_recomp;
    assign o_stat.cnt_nz = r_cnt != '0;
    assign o_stat.num_ge = r_num >= lim_ext;
    assign o_quo         = r_quo;

endmodule
`default_nettype wire

@@ hdl/radial_vignette_opacity.sv @@
`default_nettype none
// Radial vignette opacity. One pixel coordinate in, one opacity (0..240) out.
// A pixel whose column or row is a multiple of 4 is recomputed from its
// distance to the frame center: integer square root of dx^2 + dy^2, times
// 1000, divided by frame_width, saturated at 240. Any other pixel returns
// the last held opacity. A recomputed pixel runs the one-result-bit-per-cycle
// square root loop (COORD_BITS + 1 steps) and then, unless it saturates, the
// 8-step restoring divide, both run by the microcode sequencer. The next
// pixel is taken while a finished result waits in the output register.
// Configuration writes are always ready.
module radial_vignette_opacity #(
    parameter int COORD_BITS = rvo_pkg::COORD_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire [COORD_BITS-1:0]           i_pixel_x,
    input  wire [COORD_BITS-1:0]           i_pixel_y,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [rvo_pkg::OPACITY_W-1:0]  o_opacity,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [rvo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [COORD_BITS-1:0]           i_cfg_data
);
    import rvo_pkg::*;

    logic [COORD_BITS-1:0] r_frame_width, r_frame_height;
    logic                  r_out_valid;
    logic [OPACITY_W-1:0]  r_opacity;

    t_ctl     ctl;
    t_stat    stat;
    t_dp_stat dp_stat;
    logic [OPACITY_W-1:0] quo;
    logic     in_acc;
    logic     out_busy;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_busy    = r_out_valid && i_out_stall;
    assign stat        = '{in_acc: in_acc, out_busy: out_busy, dp: dp_stat};
    assign o_out_valid = r_out_valid;
    assign o_opacity   = r_opacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= COORD_BITS'(FRAME_WIDTH_RST);
            r_frame_height <= COORD_BITS'(FRAME_HEIGHT_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.en && ctl.op == OP_DONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en && ctl.op == OP_DONE) begin
            r_opacity <= quo;
        end
    end

    rvo_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .o_ctl      (ctl),
        .o_in_stall (o_in_stall)
    );

    rvo_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_stat         (dp_stat),
        .o_quo          (quo)
    );

    a_opacity_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_opacity <= OPACITY_W'(OPACITY_MAX))
        else $error("opacity above saturation limit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken again right after a transfer");

    a_done_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.en && ctl.op == OP_DONE) |-> !out_busy)
        else $error("result written over a pending transfer");

    a_cfg_unknown_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index != REG_FRAME_WIDTH && i_cfg_index != REG_FRAME_HEIGHT)
        |=> $stable(r_frame_width) && $stable(r_frame_height))
        else $error("write to unknown register changed configuration");

endmodule
`default_nettype wire
